// ----- rtl/core/mkd_pkg.sv -----
// shared types, codes and the itu symbol table for the morse key decoder
// no dependencies; imported by the decoder unit and its checker
package mkd_pkg;

    localparam int TEXT_MAX_DEF = 16;
    localparam int SYM_MAX      = 6;
    localparam int SYM_W        = 3;
    localparam int CHAR_W       = 7;
    localparam int LEN_W        = 5;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    typedef enum logic [1:0] {
        TONE_NONE  = 2'd0,
        TONE_DOT   = 2'd1,
        TONE_DASH  = 2'd2,
        TONE_SPACE = 2'd3
    } t_tone;

    typedef enum logic [2:0] {
        ACT_NONE         = 3'd0,
        ACT_ELEM_ADD     = 3'd1,
        ACT_SYM_RESTART  = 3'd2,
        ACT_CHAR_ADD     = 3'd3,
        ACT_TEXT_RESTART = 3'd4,
        ACT_CMD_BACK     = 3'd5,
        ACT_CMD_CLEAR    = 3'd6,
        ACT_UNKNOWN      = 3'd7
    } t_action;

    typedef struct packed {
        logic dash_key_n;
        logic dot_key_n;
        logic space_key_n;
        logic back_key_n;
    } t_key_sample;

    typedef struct packed {
        logic                  changed;
        t_tone                 tone_kind;
        t_action               action;
        logic [CHAR_W-1:0]     decoded_char;
        logic                  back_removed;
        logic [LEN_W-1:0]      text_length;
        logic [CHAR_W-1:0]     text_last_char;
        logic [SYM_MAX-1:0]    symbol_elements;
        logic [SYM_W-1:0]      symbol_length;
    } t_dec_result;

    // itu lookup: bit i of the key is element i (1 dash, 0 dot), 0 if unknown
    function automatic logic [CHAR_W-1:0] itu_lookup(
        input logic [SYM_W-1:0]   len,
        input logic [SYM_MAX-1:0] elems
    );
        logic [SYM_MAX-1:0]       masked;
        logic [CHAR_W-1:0]        ch;
        masked = elems & ~(6'h3f << len);
        unique case ({len, masked})
            {3'd2, 6'b000010}: ch = 7'h41; // A
            {3'd4, 6'b000001}: ch = 7'h42; // B
            {3'd4, 6'b000101}: ch = 7'h43; // C
            {3'd3, 6'b000001}: ch = 7'h44; // D
            {3'd1, 6'b000000}: ch = 7'h45; // E
            {3'd4, 6'b000100}: ch = 7'h46; // F
            {3'd3, 6'b000011}: ch = 7'h47; // G
            {3'd4, 6'b000000}: ch = 7'h48; // H
            {3'd2, 6'b000000}: ch = 7'h49; // I
            {3'd4, 6'b001110}: ch = 7'h4a; // J
            {3'd3, 6'b000101}: ch = 7'h4b; // K
            {3'd4, 6'b000010}: ch = 7'h4c; // L
            {3'd2, 6'b000011}: ch = 7'h4d; // M
            {3'd2, 6'b000001}: ch = 7'h4e; // N
            {3'd3, 6'b000111}: ch = 7'h4f; // O
            {3'd4, 6'b000110}: ch = 7'h50; // P
            {3'd4, 6'b001011}: ch = 7'h51; // Q
            {3'd3, 6'b000010}: ch = 7'h52; // R
            {3'd3, 6'b000000}: ch = 7'h53; // S
            {3'd1, 6'b000001}: ch = 7'h54; // T
            {3'd3, 6'b000100}: ch = 7'h55; // U
            {3'd4, 6'b001000}: ch = 7'h56; // V
            {3'd3, 6'b000110}: ch = 7'h57; // W
            {3'd4, 6'b001001}: ch = 7'h58; // X
            {3'd4, 6'b001101}: ch = 7'h59; // Y
            {3'd4, 6'b000011}: ch = 7'h5a; // Z
            {3'd5, 6'b011111}: ch = 7'h30; // 0
            {3'd5, 6'b011110}: ch = 7'h31; // 1
            {3'd5, 6'b011100}: ch = 7'h32; // 2
            {3'd5, 6'b011000}: ch = 7'h33; // 3
            {3'd5, 6'b010000}: ch = 7'h34; // 4
            {3'd5, 6'b000000}: ch = 7'h35; // 5
            {3'd5, 6'b000001}: ch = 7'h36; // 6
            {3'd5, 6'b000011}: ch = 7'h37; // 7
            {3'd5, 6'b000111}: ch = 7'h38; // 8
            {3'd5, 6'b001111}: ch = 7'h39; // 9
            default:           ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/core/morse_key_decoder_unit.sv -----
// morse key decoder: an input transfer is registered in stage 1, then in the output
// register; one sample per cycle while the result channel does not stall. the text
// store is one memory with at most one write and one registered read per sample,
// plus a write-to-read forward. reset is synchronous, active low; the text memory
// is not cleared, only data below the fill count is used. depends on mkd_pkg
module morse_key_decoder_unit
    import mkd_pkg::*;
#(
    parameter int TEXT_MAX = TEXT_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // key sample channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_key_sample i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_dec_result o_out_data,
    // back_enable register
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata
);

    localparam int CW = $clog2(TEXT_MAX + 1);
    localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    logic               r_back_en;
    logic               r_prev_dash, r_prev_dot, r_prev_space;
    logic [SYM_MAX-1:0] r_sym, n_sym;
    logic [SYM_W-1:0]   r_sym_cnt, n_sym_cnt;
    logic [CW-1:0]      r_text_cnt, n_text_cnt;

    // text store, one write and one registered read port
    logic [CHAR_W-1:0]  r_text_mem [TEXT_MAX];
    logic [CHAR_W-1:0]  r_rd_data;

    // stage 1: result fields waiting for the memory read data
    logic               r_s1_valid;
    t_dec_result        r_s1, n_s1;
    logic               r_s1_nz, n_s1_nz;       // text not empty after the sample
    logic               r_s1_fwd, n_s1_fwd;     // last char was written this sample
    logic [CHAR_W-1:0]  r_s1_fwd_data;

    // output register
    logic               r_out_valid;
    t_dec_result        r_out, n_out;

    logic               in_xfer, out_load, s1_free;
    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [CHAR_W-1:0]  wr_data;

    // ---------------------------------------------------------------
    // handshake: s1 moves into the output register when it is free
    // ---------------------------------------------------------------
    assign out_load   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign s1_free    = !r_s1_valid || out_load;
    assign o_in_stall = !s1_free;
    assign in_xfer    = i_in_valid && s1_free;

    // ---------------------------------------------------------------
    // per-sample update: tone, symbol, text count, store access
    // ---------------------------------------------------------------
    always_comb begin
        t_tone             tone;
        logic [CHAR_W-1:0] ch;
        logic [CW-1:0]     cnt_t;
        logic              removed;

        tone       = TONE_NONE;
        n_sym      = r_sym;
        n_sym_cnt  = r_sym_cnt;
        cnt_t      = r_text_cnt;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = CHAR_NONE;
        n_s1       = '0;

        // falling edges, dash beats dot beats space
        if (!i_in_data.dash_key_n && r_prev_dash) begin
            tone = TONE_DASH;
        end else if (!i_in_data.dot_key_n && r_prev_dot) begin
            tone = TONE_DOT;
        end else if (!i_in_data.space_key_n && r_prev_space) begin
            tone = TONE_SPACE;
        end

        ch = (r_sym_cnt == '0) ? CHAR_SPACE : itu_lookup(r_sym_cnt, r_sym);

        case (tone) inside
            TONE_DOT, TONE_DASH: begin
                if (r_sym_cnt >= SYM_W'(SYM_MAX)) begin
                    // seventh element starts a new symbol
                    n_sym       = SYM_MAX'(tone == TONE_DASH);
                    n_sym_cnt   = SYM_W'(1);
                    n_s1.action = ACT_SYM_RESTART;
                end else begin
                    n_sym       = r_sym | (SYM_MAX'(tone == TONE_DASH) << r_sym_cnt);
                    n_sym_cnt   = r_sym_cnt + SYM_W'(1);
                    n_s1.action = ACT_ELEM_ADD;
                end
            end
            TONE_SPACE: begin
                if (ch != CHAR_NONE) begin
                    n_s1.decoded_char = ch;
                    wr_en             = 1'b1;
                    wr_data           = ch;
                    if (r_text_cnt < CW'(TEXT_MAX)) begin
                        wr_addr     = AW'(r_text_cnt);
                        cnt_t       = r_text_cnt + CW'(1);
                        n_s1.action = ACT_CHAR_ADD;
                    end else begin
                        // full text restarts with the new character
                        wr_addr     = '0;
                        cnt_t       = CW'(1);
                        n_s1.action = ACT_TEXT_RESTART;
                    end
                end else if (r_sym_cnt == SYM_W'(SYM_MAX) && r_sym == '0) begin
                    // six dots: backspace command
                    if (r_text_cnt != '0) begin
                        cnt_t = r_text_cnt - CW'(1);
                    end
                    n_s1.action = ACT_CMD_BACK;
                end else if (r_sym_cnt == SYM_W'(SYM_MAX) && r_sym == '1) begin
                    // six dashes: clear command
                    cnt_t       = '0;
                    n_s1.action = ACT_CMD_CLEAR;
                end else begin
                    n_s1.action = ACT_UNKNOWN;
                end
                n_sym     = '0;
                n_sym_cnt = '0;
            end
            default: begin
            end
        endcase

        // back key acts after the tone of the same sample
        removed    = r_back_en && !i_in_data.back_key_n && (cnt_t != '0);
        n_text_cnt = removed ? cnt_t - CW'(1) : cnt_t;

        // last character sits at count-1; forward a same-cycle write there
        rd_addr  = AW'(n_text_cnt - CW'(1));
        n_s1_nz  = (n_text_cnt != '0);
        n_s1_fwd = wr_en && (wr_addr == rd_addr);

        n_s1.changed         = (tone != TONE_NONE);
        n_s1.tone_kind       = tone;
        n_s1.back_removed    = removed;
        n_s1.text_length     = LEN_W'(n_text_cnt);
        n_s1.symbol_elements = n_sym;
        n_s1.symbol_length   = n_sym_cnt;
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_en    <= 1'b1;
            r_prev_dash  <= 1'b1;
            r_prev_dot   <= 1'b1;
            r_prev_space <= 1'b1;
            r_sym        <= '0;
            r_sym_cnt    <= '0;
            r_text_cnt   <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_back_en <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_prev_dash  <= i_in_data.dash_key_n;
                r_prev_dot   <= i_in_data.dot_key_n;
                r_prev_space <= i_in_data.space_key_n;
                r_sym        <= n_sym;
                r_sym_cnt    <= n_sym_cnt;
                r_text_cnt   <= n_text_cnt;
            end
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // text memory: write the new character, read the last one
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer && wr_en) begin
            r_text_mem[wr_addr] <= wr_data;
        end
        if (in_xfer) begin
            r_rd_data <= r_text_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    // last char: none for an empty text, else forwarded write or read data
    always_comb begin
        n_out = r_s1;
        if (!r_s1_nz) begin
            n_out.text_last_char = CHAR_NONE;
        end else if (r_s1_fwd) begin
            n_out.text_last_char = r_s1_fwd_data;
        end else begin
            n_out.text_last_char = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1          <= n_s1;
            r_s1_nz       <= n_s1_nz;
            r_s1_fwd      <= n_s1_fwd;
            r_s1_fwd_data <= wr_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/mkd_checker.sv -----
// port-level checks for the morse key decoder unit, with its bind
// depends on mkd_pkg and binds into morse_key_decoder_unit
module mkd_checker
    import mkd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_dec_result o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // empty text reads as no last character
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.text_length == '0 |-> o_out_data.text_last_char == CHAR_NONE)
        else $error("last char shown for empty text");

    // a tone flag agrees with its kind
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.changed == (o_out_data.tone_kind != TONE_NONE))
        else $error("changed flag and tone kind disagree");

    // a decoded character lands in the text, and is the last one unless backed out
    a_char_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.back_removed
            && (o_out_data.action == ACT_CHAR_ADD || o_out_data.action == ACT_TEXT_RESTART)
        |-> o_out_data.decoded_char != CHAR_NONE
            && o_out_data.text_last_char == o_out_data.decoded_char)
        else $error("decoded char not shown as last char");

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
